[design/ubt_pkg.sv]
// ----------------------------------------------------------------------------
// ubt_pkg
// Shared types and constants for the used block table.
// ----------------------------------------------------------------------------
`default_nettype none

package ubt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int ADDRESS_BITS  = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_LOOKUP  = 2'd1;
  localparam logic [1:0] MODE_DELETE  = 2'd2;
  localparam logic [1:0] MODE_MEASURE = 2'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_MEASURE
  } state_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
  } match_t;

endpackage

`default_nettype wire

[design/used_block_table.sv]
// ----------------------------------------------------------------------------
// used_block_table
// Fixed table of used memory blocks with insert, lookup, delete and a
// free-run measure that steps one address per cycle through a shared
// compare unit.
// ----------------------------------------------------------------------------
// Insert, lookup, delete: accept enters S_OP, which registers done; a new
//   transaction can be started in the cycle done is high.
// Measure: steps until a hit, the end address or count passing the threshold;
//   count is the result; one address is checked against every slot per cycle.
// Results are strobed for one cycle on done; the receiver cannot stall.
// Synchronous reset clears the sequencer, done and all slot valid bits.
`default_nettype none

module used_block_table
  import ubt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] address,
  input  wire logic [15:0] block_size,
  input  wire logic [15:0] end_address,
  input  wire logic [15:0] size_threshold,
  output logic             done,
  output logic [1:0]       status,
  output logic [16:0]      size_value
);

  state_t state, state_next;

  logic [1:0]              op_mode;
  logic [ADDRESS_BITS-1:0] cur, cur_next;
  logic [ADDRESS_BITS-1:0] stop_addr;
  logic [15:0]             new_size;
  logic [15:0]             limit;
  logic [16:0]             count, count_next;

  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [ADDRESS_BITS-1:0]  slot_start  [TABLE_ENTRIES];
  logic [15:0]              slot_length [TABLE_ENTRIES];

  logic             accept;
  logic             step;
  logic             ins_en;
  logic             del_en;
  logic             done_next;
  status_t          status_next;
  logic [16:0]      value_next;
  status_t          status_q;
  match_t           m;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign status = status_q;

  ubt_match u_match (
    .key    (cur),
    .valid  (slot_valid),
    .starts (slot_start),
    .result (m)
  );

  assign step = !m.hit && (count <= {1'b0, limit}) && (cur < stop_addr);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (mode == MODE_MEASURE) ? S_MEASURE : S_OP;
        end
      end
      S_OP: begin
        state_next = S_IDLE;
      end
      S_MEASURE: begin
        if (!step) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cur_next    = cur;
    count_next  = count;
    ins_en      = 1'b0;
    del_en      = 1'b0;
    done_next   = 1'b0;
    status_next = ST_OK;
    value_next  = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur_next   = ADDRESS_BITS'(address);
          count_next = '0;
        end
      end
      S_OP: begin
        done_next = 1'b1;
        unique case (op_mode)
          MODE_INSERT: begin
            if (m.free_ok) begin
              ins_en = 1'b1;
            end else begin
              status_next = ST_FULL;
            end
          end
          MODE_LOOKUP: begin
            if (m.hit) begin
              value_next = 17'(slot_length[m.hit_idx]);
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
          MODE_DELETE: begin
            if (m.hit) begin
              del_en = 1'b1;
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
          default: begin
            status_next = ST_OK;
          end
        endcase
      end
      S_MEASURE: begin
        if (step) begin
          cur_next   = cur + 1'b1;
          count_next = count + 17'd1;
        end else begin
          done_next  = 1'b1;
          value_next = count;
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      slot_valid <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (ins_en) begin
        slot_valid[m.free_idx] <= 1'b1;
      end
      if (del_en) begin
        slot_valid[m.hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur   <= cur_next;
    count <= count_next;
    if (accept) begin
      op_mode   <= mode;
      new_size  <= block_size;
      stop_addr <= ADDRESS_BITS'(end_address);
      limit     <= size_threshold;
    end
    if (ins_en) begin
      slot_start[m.free_idx]  <= cur;
      slot_length[m.free_idx] <= new_size;
    end
    if (done_next) begin
      status_q   <= status_next;
      size_value <= value_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("transaction accepted without going busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MEASURE) |-> (count <= (17'(limit) + 17'd1)))
    else $error("measure count ran past threshold plus one");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobed while busy");
`endif

endmodule

`default_nettype wire

[design/ubt_match.sv]
// ----------------------------------------------------------------------------
// ubt_match
// Shared compare unit: lowest valid slot whose start equals the key, and the
// lowest free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ubt_match
  import ubt_pkg::*;
(
  input  wire logic [ADDRESS_BITS-1:0] key,
  input  wire logic [TABLE_ENTRIES-1:0] valid,
  input  wire logic [ADDRESS_BITS-1:0] starts [TABLE_ENTRIES],
  output match_t                         result
);

  always_comb begin
    result = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && (starts[i] == key)) begin
        result.hit     = 1'b1;
        result.hit_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        result.free_ok  = 1'b1;
        result.free_idx = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire
